/* design/taeh_pkg.sv */
// ----------------------------------------------------------------------------
// taeh_pkg
// Shared types, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package taeh_pkg;

    localparam int HYST_DEG  = 5;
    localparam int HALF_TURN = 180;
    localparam int DEG_FRAC  = 16;   // angle accumulator: 2^-16 degree units
    localparam int ATAN_LEN  = 24;

    localparam logic [16:0] RST_EMA_WEIGHT      = 17'd6554;
    localparam logic [7:0]  RST_TILT_THRESHOLD  = 8'd30;
    localparam logic        RST_MIRROR_XY       = 1'b0;
    localparam logic [7:0]  RST_REPORT_INTERVAL = 8'd10;

    typedef enum logic [1:0] {
        REG_EMA_WEIGHT      = 2'd0,
        REG_TILT_THRESHOLD  = 2'd1,
        REG_MIRROR_XY       = 2'd2,
        REG_REPORT_INTERVAL = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [16:0] ema_weight;
        logic [7:0]  tilt_threshold;
        logic        mirror_xy;
        logic [7:0]  report_interval;
    } t_cfg;

    // filtered vector handed from the filter to the angle pipeline
    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
    } t_job;

    // atan(2^-i) in degrees, scaled by 2^16
    function automatic logic [21:0] atan_deg(input int i);
        logic [21:0] v;
        case (i)
            0:       v = 22'd2949120;
            1:       v = 22'd1740967;
            2:       v = 22'd919879;
            3:       v = 22'd466945;
            4:       v = 22'd234379;
            5:       v = 22'd117304;
            6:       v = 22'd58666;
            7:       v = 22'd29335;
            8:       v = 22'd14668;
            9:       v = 22'd7334;
            10:      v = 22'd3667;
            11:      v = 22'd1833;
            12:      v = 22'd917;
            13:      v = 22'd458;
            14:      v = 22'd229;
            15:      v = 22'd115;
            16:      v = 22'd57;
            17:      v = 22'd29;
            18:      v = 22'd14;
            19:      v = 22'd7;
            20:      v = 22'd4;
            21:      v = 22'd2;
            22:      v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* design/taeh_if.sv */
// ----------------------------------------------------------------------------
// taeh_if
// Valid/ready channels: sample input, report output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface taeh_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               read_failed;
    modport source (output valid, accel_x, accel_y, accel_z, read_failed, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, read_failed, output ready);
endinterface

interface taeh_rpt_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] x_angle;
    logic signed [8:0] y_angle;
    logic              tilted;
    logic              tilt_alarm;
    modport source (output valid, x_angle, y_angle, tilted, tilt_alarm, input ready);
    modport sink   (input valid, x_angle, y_angle, tilted, tilt_alarm, output ready);
endinterface

interface taeh_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/taeh_front.sv */
// ----------------------------------------------------------------------------
// taeh_front
// Sample intake: conditioning, per-axis EMA filter and report counting.
// ----------------------------------------------------------------------------
`default_nettype none

module taeh_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    taeh_smp_if.sink           i_smp,
    input  wire taeh_pkg::t_cfg i_cfg,
    input  wire logic          i_full,
    output logic               o_push,
    output taeh_pkg::t_job     o_job
);

    localparam int SW = (17 + FRAC_BITS > 33) ? 17 + FRAC_BITS : 33;
    localparam logic signed [SW-1:0] SMAX = SW'(33'sh0_7FFF_FFFF);
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    function automatic logic signed [31:0] to_fixed(input logic signed [16:0] raw);
        logic signed [SW-1:0] s;
        logic signed [31:0]   r;
        s = SW'(raw) <<< FRAC_BITS;
        if (s > SMAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (s < SMIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] ema(input logic signed [31:0] f,
                                               input logic signed [31:0] s,
                                               input logic [16:0] w);
        logic signed [32:0] d;
        logic signed [50:0] p;
        logic signed [50:0] q;
        d = 33'(s) - 33'(f);
        p = 51'(d) * 51'(signed'({1'b0, w}));
        q = (p + 51'sd32768) >>> 16;
        return f + q[31:0];
    endfunction

    logic signed [31:0] r_fx, r_fy, r_fz;
    logic signed [31:0] n_fx, n_fy, n_fz;
    logic [7:0]         r_cnt, n_cnt;
    logic               r_primed;
    logic signed [16:0] rx, ry, rz;
    logic [16:0]        w;
    logic [7:0]         interval;
    logic [7:0]         cnt_inc;
    logic               accept;
    logic               due;

    assign i_smp.ready = !i_full;
    assign accept      = i_smp.valid && !i_full;

    always_comb begin
        rx = i_smp.read_failed ? 17'sd0 : 17'(i_smp.accel_x);
        ry = i_smp.read_failed ? 17'sd0 : 17'(i_smp.accel_y);
        rz = i_smp.read_failed ? 17'sd0 : 17'(i_smp.accel_z);
        if (i_cfg.mirror_xy) begin
            rx = -rx;
            ry = -ry;
        end
        w        = (i_cfg.ema_weight > 17'd65536) ? 17'd65536 : i_cfg.ema_weight;
        interval = (i_cfg.report_interval == 8'd0) ? 8'd1 : i_cfg.report_interval;
        cnt_inc  = r_cnt + 8'd1;
        due      = cnt_inc >= interval;
        if (r_primed) begin
            n_fx = ema(r_fx, to_fixed(rx), w);
            n_fy = ema(r_fy, to_fixed(ry), w);
            n_fz = ema(r_fz, to_fixed(rz), w);
            n_cnt = due ? 8'd0 : cnt_inc;
        end else begin
            // first sample loads the filter and is not counted
            n_fx  = to_fixed(rx);
            n_fy  = to_fixed(ry);
            n_fz  = to_fixed(rz);
            n_cnt = r_cnt;
        end
    end

    assign o_push   = accept && r_primed && due;
    assign o_job.fx = n_fx;
    assign o_job.fy = n_fy;
    assign o_job.fz = n_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx     <= '0;
            r_fy     <= '0;
            r_fz     <= '0;
            r_cnt    <= '0;
            r_primed <= 1'b0;
        end else if (accept) begin
            r_fx     <= n_fx;
            r_fy     <= n_fy;
            r_fz     <= n_fz;
            r_cnt    <= n_cnt;
            r_primed <= 1'b1;
        end
    end

endmodule

`default_nettype wire

/* design/taeh_fifo.sv */
// ----------------------------------------------------------------------------
// taeh_fifo
// Two-entry queue between the filter and the angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module taeh_fifo #(
    parameter int W = 96
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_full,
    output logic              o_empty,
    output logic [W-1:0]      o_data
);

    logic [W-1:0] r_mem [0:1];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

/* design/taeh_cordic.sv */
// ----------------------------------------------------------------------------
// taeh_cordic
// Pipelined vectoring CORDIC: atan2(y, z) in whole degrees, toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module taeh_cordic #(
    parameter int ANGLE_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_y,
    input  wire logic signed [31:0] i_z,
    output logic signed [8:0]       o_deg
);

    localparam int XW = 36;
    localparam int AW = 28;
    localparam int QW = AW - taeh_pkg::DEG_FRAC;
    localparam logic signed [AW-1:0] ACC_HALF =
        AW'(taeh_pkg::HALF_TURN) <<< taeh_pkg::DEG_FRAC;

    logic signed [XW-1:0] r_x   [0:ANGLE_STEPS];
    logic signed [XW-1:0] r_y   [0:ANGLE_STEPS];
    logic signed [AW-1:0] r_acc [0:ANGLE_STEPS];
    logic                 r_zy  [0:ANGLE_STEPS];
    logic                 r_zn  [0:ANGLE_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zy[0] <= i_y == 32'sd0;
            r_zn[0] <= i_z < 32'sd0;
            if (i_z < 32'sd0) begin
                // fold into the right half plane
                r_x[0]   <= -XW'(i_z);
                r_y[0]   <= -XW'(i_y);
                r_acc[0] <= (i_y >= 32'sd0) ? ACC_HALF : -ACC_HALF;
            end else begin
                r_x[0]   <= XW'(i_z);
                r_y[0]   <= XW'(i_y);
                r_acc[0] <= '0;
            end
        end
    end

    for (genvar k = 1; k <= ANGLE_STEPS; k++) begin : g_step
        logic signed [XW-1:0] xs, ys;
        logic signed [AW-1:0] a;
        assign xs = r_x[k-1] >>> (k - 1);
        assign ys = r_y[k-1] >>> (k - 1);
        assign a  = AW'({1'b0, taeh_pkg::atan_deg(k - 1)});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zy[k] <= r_zy[k-1];
                r_zn[k] <= r_zn[k-1];
                if (!r_y[k-1][XW-1]) begin
                    r_x[k]   <= r_x[k-1] + ys;
                    r_y[k]   <= r_y[k-1] - xs;
                    r_acc[k] <= r_acc[k-1] + a;
                end else begin
                    r_x[k]   <= r_x[k-1] - ys;
                    r_y[k]   <= r_y[k-1] + xs;
                    r_acc[k] <= r_acc[k-1] - a;
                end
            end
        end
    end

    logic signed [AW-1:0] acc;
    logic signed [QW-1:0] q;

    always_comb begin
        acc = r_acc[ANGLE_STEPS];
        q   = acc[AW-1:taeh_pkg::DEG_FRAC];
        if (acc[AW-1] && acc[taeh_pkg::DEG_FRAC-1:0] != '0) begin
            q = q + QW'(1);
        end
        if (r_zy[ANGLE_STEPS]) begin
            o_deg = r_zn[ANGLE_STEPS] ? 9'sd180 : 9'sd0;
        end else if (q > QW'(taeh_pkg::HALF_TURN)) begin
            o_deg = 9'sd180;
        end else if (q < -QW'(taeh_pkg::HALF_TURN)) begin
            o_deg = -9'sd180;
        end else begin
            o_deg = q[8:0];
        end
    end

endmodule

`default_nettype wire

/* design/taeh_back.sv */
// ----------------------------------------------------------------------------
// taeh_back
// Angle pipeline for both axes, hysteresis flag and report register.
// ----------------------------------------------------------------------------
`default_nettype none

module taeh_back #(
    parameter int ANGLE_STEPS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire taeh_pkg::t_job i_job,
    input  wire logic [7:0]     i_thr,
    output logic                o_pop,
    taeh_rpt_if.source          o_rpt
);

    logic [ANGLE_STEPS:0] r_v;
    logic                 r_out_v;
    logic                 r_lat;
    logic signed [8:0]    r_xa, r_ya;
    logic                 r_alarm;
    logic                 en;
    logic signed [8:0]    xa, ya;
    logic [7:0]           ax, ay;
    logic signed [9:0]    thr, clr;
    logic                 set_t, clr_t;

    assign en    = !r_out_v || o_rpt.ready;
    assign o_pop = en && !i_empty;

    taeh_cordic #(.ANGLE_STEPS(ANGLE_STEPS)) u_cx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (i_job.fy),
        .i_z   (i_job.fz),
        .o_deg (xa)
    );

    taeh_cordic #(.ANGLE_STEPS(ANGLE_STEPS)) u_cy (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (i_job.fx),
        .i_z   (i_job.fz),
        .o_deg (ya)
    );

    always_comb begin
        ax    = xa[8] ? 8'(-xa) : xa[7:0];
        ay    = ya[8] ? 8'(-ya) : ya[7:0];
        thr   = signed'({2'b00, i_thr});
        clr   = thr - 10'(taeh_pkg::HYST_DEG);
        set_t = (ax >= i_thr || ay >= i_thr) && !r_lat;
        clr_t = signed'({2'b00, ax}) < clr && signed'({2'b00, ay}) < clr && r_lat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
            r_lat   <= 1'b0;
        end else if (en) begin
            r_v     <= {r_v[ANGLE_STEPS-1:0], !i_empty};
            r_out_v <= r_v[ANGLE_STEPS];
            if (r_v[ANGLE_STEPS]) begin
                if (set_t) begin
                    r_lat <= 1'b1;
                end else if (clr_t) begin
                    r_lat <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v[ANGLE_STEPS]) begin
            r_xa    <= xa;
            r_ya    <= ya;
            r_alarm <= set_t;
        end
    end

    assign o_rpt.valid      = r_out_v;
    assign o_rpt.x_angle    = r_xa;
    assign o_rpt.y_angle    = r_ya;
    assign o_rpt.tilted     = r_lat;
    assign o_rpt.tilt_alarm = r_alarm;

endmodule

`default_nettype wire

/* design/tilt_angle_ema_hysteresis.sv */
// ----------------------------------------------------------------------------
// tilt_angle_ema_hysteresis
// Accelerometer tilt angles with EMA smoothing and a hysteresis tilt flag.
// ----------------------------------------------------------------------------
// Takes one sample per clock. The filter updates in the cycle a sample is
// taken; every report_interval samples the filtered vector goes into a
// two-entry queue that feeds a pipelined CORDIC pair (one register stage for
// quadrant folding plus ANGLE_STEPS iteration stages), then the hysteresis
// logic and the report register. A report goes valid once the sample
// triggering it has passed the queue, the CORDIC stages and the report
// register; the sample input drops ready only while the queue is full.
`default_nettype none

module tilt_angle_ema_hysteresis #(
    parameter int FRAC_BITS   = 16,
    parameter int ANGLE_STEPS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    taeh_smp_if.sink   i_smp,
    taeh_cfg_if.sink   i_cfg,
    taeh_rpt_if.source o_rpt
);

    taeh_pkg::t_cfg r_cfg;
    taeh_pkg::t_job push_job;
    taeh_pkg::t_job pop_job;
    logic           push, pop, full, empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ema_weight      <= taeh_pkg::RST_EMA_WEIGHT;
            r_cfg.tilt_threshold  <= taeh_pkg::RST_TILT_THRESHOLD;
            r_cfg.mirror_xy       <= taeh_pkg::RST_MIRROR_XY;
            r_cfg.report_interval <= taeh_pkg::RST_REPORT_INTERVAL;
        end else if (i_cfg.valid) begin
            case (taeh_pkg::t_reg_idx'(i_cfg.index))
                taeh_pkg::REG_EMA_WEIGHT:      r_cfg.ema_weight      <= i_cfg.data;
                taeh_pkg::REG_TILT_THRESHOLD:  r_cfg.tilt_threshold  <= i_cfg.data[7:0];
                taeh_pkg::REG_MIRROR_XY:       r_cfg.mirror_xy       <= i_cfg.data[0];
                taeh_pkg::REG_REPORT_INTERVAL: r_cfg.report_interval <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    taeh_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (i_smp),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    taeh_fifo #(.W($bits(taeh_pkg::t_job))) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (pop_job)
    );

    taeh_back #(.ANGLE_STEPS(ANGLE_STEPS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (pop_job),
        .i_thr   (r_cfg.tilt_threshold),
        .o_pop   (pop),
        .o_rpt   (o_rpt)
    );

endmodule

`default_nettype wire

/* tb/taeh_tb_if.sv */
// ----------------------------------------------------------------------------
// taeh_tb_if
// Bench-side sample and report records, used with the block's interfaces.
// ----------------------------------------------------------------------------
// The block ports take the design interfaces directly; this file only holds
// the sample and report records that the checker uses.
package taeh_tb_pkg;
    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               fail;
    } t_sample;

    typedef struct {
        logic signed [8:0] xa;
        logic signed [8:0] ya;
        logic              tilted;
        logic              alarm;
    } t_report;
endpackage

/* tb/tilt_checker.sv */
// ----------------------------------------------------------------------------
// tilt_checker
// Watches the sample, config and report channels and checks every report.
// ----------------------------------------------------------------------------
module tilt_checker #(
    parameter int FRAC_BITS   = 16,
    parameter int ANGLE_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    taeh_smp_if         smp,
    taeh_cfg_if         cfg,
    taeh_rpt_if         rpt,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    taeh_tb_pkg::t_report report_q[$];
    taeh_pkg::t_cfg       regs;
    logic signed [31:0] flt_x, flt_y, flt_z;
    logic [7:0] count;
    logic       latched;
    logic       primed;
    int         errors = 0;

    assign o_errors = errors;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [31:0] fix(longint raw);
        longint s;
        s = raw * (longint'(1) << FRAC_BITS);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] smooth(logic signed [31:0] f,
                                                  logic signed [31:0] s, longint w);
        longint d;
        d = longint'(s) - longint'(f);
        return 32'(longint'(f) + floor_shift(d * w + 32768, 16));
    endfunction

    function automatic int tilt_deg(logic signed [31:0] yi, logic signed [31:0] zi);
        longint x, y, acc, xs, ys, deg;
        x = zi;
        y = yi;
        acc = 0;
        if (yi == 0) return (zi < 0) ? taeh_pkg::HALF_TURN : 0;
        if (zi < 0) begin
            acc = ((yi >= 0) ? taeh_pkg::HALF_TURN : -taeh_pkg::HALF_TURN) *
                  (longint'(1) << taeh_pkg::DEG_FRAC);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ANGLE_STEPS && i < taeh_pkg::ATAN_LEN; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; acc += longint'(taeh_pkg::atan_deg(i));
            end else begin
                x = x - ys; y = y + xs; acc -= longint'(taeh_pkg::atan_deg(i));
            end
        end
        deg = acc / (longint'(1) << taeh_pkg::DEG_FRAC);  // truncates toward zero
        if (deg > taeh_pkg::HALF_TURN) deg = taeh_pkg::HALF_TURN;
        if (deg < -taeh_pkg::HALF_TURN) deg = -taeh_pkg::HALF_TURN;
        return int'(deg);
    endfunction

    task automatic take_sample(taeh_tb_pkg::t_sample s);
        longint rx, ry, rz, w;
        int xa, ya, ax, ay, thr, ivl;
        logic signed [31:0] sx, sy, sz;
        taeh_tb_pkg::t_report r;
        rx = s.ax; ry = s.ay; rz = s.az;
        w = (regs.ema_weight > 17'd65536) ? 65536 : longint'(regs.ema_weight);
        ivl = (regs.report_interval == 0) ? 1 : int'(regs.report_interval);
        thr = int'(regs.tilt_threshold);
        if (s.fail) begin
            rx = 0; ry = 0; rz = 0;
        end
        if (regs.mirror_xy) begin
            rx = -rx; ry = -ry;
        end
        sx = fix(rx); sy = fix(ry); sz = fix(rz);
        if (!primed) begin
            flt_x = sx; flt_y = sy; flt_z = sz;
            primed = 1'b1;
            return;
        end
        flt_x = smooth(flt_x, sx, w);
        flt_y = smooth(flt_y, sy, w);
        flt_z = smooth(flt_z, sz, w);
        count = count + 8'd1;
        if (int'(count) < ivl) return;
        count = '0;
        xa = tilt_deg(flt_y, flt_z);
        ya = tilt_deg(flt_x, flt_z);
        ax = (xa < 0) ? -xa : xa;
        ay = (ya < 0) ? -ya : ya;
        r.alarm = 1'b0;
        if ((ax >= thr || ay >= thr) && !latched) begin
            latched = 1'b1;
            r.alarm = 1'b1;
        end else if (ax < thr - taeh_pkg::HYST_DEG && ay < thr - taeh_pkg::HYST_DEG &&
                     latched) begin
            latched = 1'b0;
        end
        r.xa = 9'(xa);
        r.ya = 9'(ya);
        r.tilted = latched;
        report_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        taeh_tb_pkg::t_report e;
        taeh_tb_pkg::t_sample s;
        if (!i_rst_n) begin
            regs <= '{taeh_pkg::RST_EMA_WEIGHT, taeh_pkg::RST_TILT_THRESHOLD,
                      taeh_pkg::RST_MIRROR_XY, taeh_pkg::RST_REPORT_INTERVAL};
            flt_x = '0; flt_y = '0; flt_z = '0;
            count = '0; latched = 1'b0; primed = 1'b0;
            report_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (taeh_pkg::t_reg_idx'(cfg.index))
                    taeh_pkg::REG_EMA_WEIGHT:      regs.ema_weight <= cfg.data;
                    taeh_pkg::REG_TILT_THRESHOLD:  regs.tilt_threshold <= cfg.data[7:0];
                    taeh_pkg::REG_MIRROR_XY:       regs.mirror_xy <= cfg.data[0];
                    taeh_pkg::REG_REPORT_INTERVAL: regs.report_interval <= cfg.data[7:0];
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready) begin
                s = '{smp.accel_x, smp.accel_y, smp.accel_z, smp.read_failed};
                take_sample(s);
            end
            if (rpt.valid && rpt.ready) begin
                if (report_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected report x=%0d y=%0d t=%0b a=%0b",
                                 rpt.x_angle, rpt.y_angle, rpt.tilted, rpt.tilt_alarm);
                end else begin
                    e = report_q.pop_front();
                    if (e.xa !== rpt.x_angle || e.ya !== rpt.y_angle ||
                        e.tilted !== rpt.tilted || e.alarm !== rpt.tilt_alarm) begin
                        errors++;
                        if (errors <= 10)
                            $display({"report mismatch: exp x=%0d y=%0d t=%0b a=%0b,",
                                      " got x=%0d y=%0d t=%0b a=%0b"},
                                     e.xa, e.ya, e.tilted, e.alarm, rpt.x_angle,
                                     rpt.y_angle, rpt.tilted, rpt.tilt_alarm);
                    end
                end
            end
        end
        o_pending <= report_q.size();
    end
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the tilt block: directed extremes, then random sample streams.
// ----------------------------------------------------------------------------
// Drives samples and register writes on the falling edge, stalls the report
// side at random, and lets tilt_checker judge every report.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 40;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   idle_cycles = 0;

    taeh_smp_if smp();
    taeh_rpt_if rpt();
    taeh_cfg_if cfg();

    tilt_angle_ema_hysteresis u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_smp(smp), .i_cfg(cfg), .o_rpt(rpt)
    );

    tilt_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .smp(smp), .cfg(cfg), .rpt(rpt),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // report-side stall pattern
    initial begin
        int n;
        rpt.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            rpt.ready = 1'b1;
            n = (($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10));
            repeat (n) @(negedge i_clk);
            n = gap_len();
            if (n > 0) begin
                rpt.ready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (smp.valid && smp.ready) || (rpt.valid && rpt.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic f);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        smp.accel_x = x; smp.accel_y = y; smp.accel_z = z; smp.read_failed = f;
        smp.valid = 1'b1;
        do @(posedge i_clk); while (!smp.ready);
        @(negedge i_clk);
        smp.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(taeh_pkg::t_reg_idx idx, logic [16:0] val);
        cfg.index = idx; cfg.data = val; cfg.valid = 1'b1;
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    task automatic set_all(logic [16:0] w, logic [7:0] thr, logic mir, logic [7:0] ivl);
        drain();
        write_reg(taeh_pkg::REG_EMA_WEIGHT, w);
        write_reg(taeh_pkg::REG_TILT_THRESHOLD, 17'(thr));
        write_reg(taeh_pkg::REG_MIRROR_XY, 17'(mir));
        write_reg(taeh_pkg::REG_REPORT_INTERVAL, 17'(ivl));
    endtask

    // mostly a slowly wandering vector so the filter and hysteresis move
    task automatic random_run(int n);
        logic signed [15:0] bx, by, bz;
        int k;
        bx = 16'($urandom); by = 16'($urandom); bz = 16'($urandom);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 19);
            if (k == 0) send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
            else if (k < 4) send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
            else begin
                bx = bx + 16'($urandom_range(0, 4000)) - 16'sd2000;
                by = by + 16'($urandom_range(0, 4000)) - 16'sd2000;
                bz = bz + 16'($urandom_range(0, 4000)) - 16'sd2000;
                send_sample(bx, by, bz, 1'b0);
            end
        end
    endtask

    initial begin
        smp.valid = 1'b0; smp.accel_x = '0; smp.accel_y = '0; smp.accel_z = '0;
        smp.read_failed = 1'b0;
        cfg.valid = 1'b0; cfg.index = taeh_pkg::REG_EMA_WEIGHT; cfg.data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: weight one, report every sample, low threshold
        set_all(17'd65536, 8'd5, 1'b0, 8'd1);
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);          // priming
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);          // both zero
        send_sample(16'sd0, 16'sd0, -16'sd100, 1'b0);       // y zero, z negative
        send_sample(16'sd0, 16'sd100, 16'sd100, 1'b0);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        send_sample(16'sd32767, -16'sd32768, 16'sd0, 1'b0);
        send_sample(16'sd5, 16'sd5, 16'sd5, 1'b1);          // failed read
        send_sample(16'sd1, 16'sd1, 16'sd30000, 1'b0);      // low threshold: stays set
        set_all(17'd65536, 8'd180, 1'b1, 8'd1);
        send_sample(-16'sd32768, -16'sd32768, -16'sd1, 1'b0); // mirrored -32768
        send_sample(16'sd100, -16'sd1, -16'sd32768, 1'b0);
        send_sample(-16'sd1, 16'sd1, -16'sd1, 1'b0);
        set_all(17'd0, 8'd0, 1'b0, 8'd0);                   // interval zero
        send_sample(16'sd1000, 16'sd1000, 16'sd1000, 1'b0);
        send_sample(16'sd1000, 16'sd1000, 16'sd1000, 1'b0);
        set_all(17'h1FFFF, 8'd255, 1'b0, 8'd255);           // weight above one
        send_sample(16'sd2000, -16'sd3000, 16'sd10, 1'b0);
        send_sample(-16'sd2000, 16'sd3000, 16'sd10, 1'b0);
        drain();
        write_reg(taeh_pkg::REG_REPORT_INTERVAL, 17'd2);    // lowered mid-count
        send_sample(16'sd0, 16'sd100, 16'sd100, 1'b0);

        // random phases across settings
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: set_all(17'd6554, 8'd30, 1'b0, 8'd1);
                1: set_all(17'($urandom_range(0, 65536)), 8'($urandom_range(5, 180)),
                           1'($urandom), 8'($urandom_range(1, 8)));
                2: set_all(17'd65536, 8'd180, 1'b1, 8'd3);
                default: set_all(17'd1, 8'd5, 1'b0, 8'($urandom_range(1, 255)));
            endcase
            random_run(150);
        end
        drain();

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
